FILE: rtl/lcaq_pkg.sv
// ----------------------------------------------------------------------------
// lcaq_pkg: shared types and constants of the chain query engine
// Node field width, table entry layout, item kinds, sequencer states and the
// packed widths of the stream data buses.
// ----------------------------------------------------------------------------
`default_nettype none

package lcaq_pkg;

	localparam int NODE_W      = 10;
	localparam int NODES_DEF   = 1024;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 16;

	typedef logic [NODE_W-1:0] node_t;

	// One table entry: all three per-node values live in the same word.
	typedef struct packed {
		node_t parent;
		node_t depth;
		node_t leader;
	} entry_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_HOP
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/lca_chain_query_engine.sv
// ----------------------------------------------------------------------------
// lca_chain_query_engine: lowest common ancestor by chain leader walk
// Holds parent, depth and chain leader of every node in one dual-read table
// memory and answers ancestor queries by hopping over chain leaders.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Item                         Results
//  s_axis    in         table write or query         none for a write
//  m_axis    out        ancestor and failure flag    one per query
//
//  A write goes straight to the table memory. A query walks at most 2*NODES
//  chain hops; each hop is one leader read and one parent/depth read of the
//  table memory, whose read ports are registered.
//  Input is taken only while no query is being walked. A finished result waits
//  in the output register; the walk stalls only when that register is full.
//  Reset clears the sequencer and the output register, not the table.
//
`default_nettype none

module lca_chain_query_engine import lcaq_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// entry_node, entry_parent, entry_depth, entry_leader, query_x, query_y
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  wire logic                   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// ancestor
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// walk_failed
	output logic                        m_axis_tuser
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int HW = $clog2(2 * NODES + 1);
	localparam logic [HW-1:0] HOP_LIMIT = HW'(2 * NODES);

	// Input fields.
	node_t entry_node, entry_parent, entry_depth, entry_leader, query_x, query_y;
	assign entry_node   = s_axis_tdata[9:0];
	assign entry_parent = s_axis_tdata[19:10];
	assign entry_depth  = s_axis_tdata[29:20];
	assign entry_leader = s_axis_tdata[39:30];
	assign query_x      = s_axis_tdata[49:40];
	assign query_y      = s_axis_tdata[59:50];

	state_t state_q, state_d;
	node_t x_q, y_q, x_d, y_d;
	logic [HW-1:0] hops_q, hops_d;

	entry_t mem [NODES];
	entry_t rd_a_q, rd_b_q;
	logic rd_en, wr_en;
	node_t rd_addr_a, rd_addr_b;

	logic out_valid_q;
	node_t anc_q, anc_d;
	logic fail_q, fail_d, out_load, out_free;

	logic in_accept, leaders_match, hop_exhausted;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign leaders_match = (rd_a_q.leader == rd_b_q.leader);
	assign hop_exhausted = (hops_q >= HOP_LIMIT);

	function automatic logic node_ok(input node_t n);
		return 32'(n) < NODES;
	endfunction

	// Table memory: one write port, two registered read ports. A node outside
	// the table reads as all zeros.
	always_ff @(posedge clk) begin
		if (wr_en && node_ok(entry_node)) begin
			mem[AW'(entry_node)] <= '{parent: entry_parent, depth: entry_depth,
				leader: entry_leader};
		end
		if (rd_en) begin
			rd_a_q <= node_ok(rd_addr_a) ? mem[AW'(rd_addr_a)] : '0;
			rd_b_q <= node_ok(rd_addr_b) ? mem[AW'(rd_addr_b)] : '0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && s_axis_tuser == MODE_QUERY) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (leaders_match || hop_exhausted) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_HOP;
				end
			end
			ST_HOP: state_d = ST_CHECK;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_axis_tready = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr_a = x_q;
		rd_addr_b = y_q;
		x_d       = x_q;
		y_d       = y_q;
		hops_d    = hops_q;
		out_load  = 1'b0;
		anc_d     = '0;
		fail_d    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_accept) begin
					if (s_axis_tuser == MODE_WRITE) begin
						wr_en = 1'b1;
					end else begin
						rd_en     = 1'b1;
						rd_addr_a = query_x;
						rd_addr_b = query_y;
						x_d       = query_x;
						y_d       = query_y;
						hops_d    = '0;
					end
				end
			end
			ST_CHECK: begin
				if (leaders_match) begin
					out_load = out_free;
					// On equal depths the first node wins.
					anc_d = (rd_a_q.depth > rd_b_q.depth) ? y_q : x_q;
				end else if (hop_exhausted) begin
					out_load = out_free;
					fail_d   = 1'b1;
				end else begin
					rd_en     = 1'b1;
					rd_addr_a = rd_a_q.leader;
					rd_addr_b = rd_b_q.leader;
				end
			end
			ST_HOP: begin
				// The node whose leader is deeper climbs; on a tie the second one.
				if (rd_a_q.depth > rd_b_q.depth) begin
					x_d = rd_a_q.parent;
				end else begin
					y_d = rd_b_q.parent;
				end
				hops_d    = hops_q + HW'(1);
				rd_en     = 1'b1;
				rd_addr_a = x_d;
				rd_addr_b = y_d;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_d;
		y_q    <= y_d;
		hops_q <= hops_d;
		if (out_load) begin
			anc_q  <= anc_d;
			fail_q <= fail_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(anc_q);
	assign m_axis_tuser  = fail_q;

	// The walk never counts past the hop limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (hops_q <= HOP_LIMIT))
		else $error("hop counter passed the limit");

	// A new result is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("pending result overwritten");

	// An accepted query starts the walk in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_axis_tuser == MODE_QUERY) |=> (state_q == ST_CHECK))
		else $error("query did not start its walk");

	// A failed walk reports ancestor zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("failed walk with nonzero ancestor");

endmodule

`default_nettype wire

FILE: sim/tb_lca_chain_query_engine.sv
// ----------------------------------------------------------------------------
// tb_lca_chain_query_engine: self-checking testbench of the chain query engine
// Loads parent, depth and chain leader tables with write items and asks
// ancestor queries. A local chain walk predicts every answer, and a monitor
// compares each result item with the oldest predicted answer. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lca_chain_query_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import lcaq_pkg::*;

	localparam int HOP_LIMIT      = 2 * NODES_DEF;
	localparam int PAD_W          = IN_TDATA_W - 6 * NODE_W;
	// The slowest item is a walk that runs into the hop limit.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct {
		mode_t mode;
		node_t node;
		node_t parent;
		node_t depth;
		node_t leader;
		node_t qx;
		node_t qy;
	} lca_request_t;

	typedef struct {
		node_t ancestor;
		logic  failed;
	} ancestor_answer_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	// Shadow copy of the node tables.
	node_t par_tbl [NODES_DEF];
	node_t dep_tbl [NODES_DEF];
	node_t ldr_tbl [NODES_DEF];

	ancestor_answer_t pending_answers[$];
	ancestor_answer_t want;
	node_t            tree_ids[$];

	bit steady;
	int mismatches;
	int writes_sent;
	int queries_sent;
	int answers_checked;
	int hop_limit_hits;
	int quiet_cycles;

	lca_chain_query_engine #(
		.NODES(NODES_DEF)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Walks both nodes up the chains until they share a leader or reach the hop limit.
	function automatic ancestor_answer_t walk_chains(node_t x, node_t y);
		ancestor_answer_t ans;
		int hops;
		hops = 0;
		while (ldr_tbl[x] != ldr_tbl[y]) begin
			if (hops >= HOP_LIMIT) begin
				ans.ancestor = '0;
				ans.failed   = 1'b1;
				return ans;
			end
			// On a tie of leader depths the second node moves.
			if (dep_tbl[ldr_tbl[x]] > dep_tbl[ldr_tbl[y]])
				x = par_tbl[ldr_tbl[x]];
			else
				y = par_tbl[ldr_tbl[y]];
			hops++;
		end
		ans.ancestor = (dep_tbl[x] > dep_tbl[y]) ? y : x;
		ans.failed   = 1'b0;
		return ans;
	endfunction

	function automatic void apply_request(lca_request_t req);
		if (req.mode == MODE_WRITE) begin
			par_tbl[req.node] = req.parent;
			dep_tbl[req.node] = req.depth;
			ldr_tbl[req.node] = req.leader;
			writes_sent++;
		end else begin
			pending_answers.insert(pending_answers.size(), walk_chains(req.qx, req.qy));
			queries_sent++;
		end
	endfunction

	// Fields that the chosen mode ignores carry random values.
	function automatic lca_request_t make_write(node_t node, node_t parent, node_t depth,
			node_t leader);
		lca_request_t req;
		req.mode   = MODE_WRITE;
		req.node   = node;
		req.parent = parent;
		req.depth  = depth;
		req.leader = leader;
		req.qx     = node_t'($urandom);
		req.qy     = node_t'($urandom);
		return req;
	endfunction

	function automatic lca_request_t make_query(node_t x, node_t y);
		lca_request_t req;
		req.mode   = MODE_QUERY;
		req.node   = node_t'($urandom);
		req.parent = node_t'($urandom);
		req.depth  = node_t'($urandom);
		req.leader = node_t'($urandom);
		req.qx     = x;
		req.qy     = y;
		return req;
	endfunction

	task automatic send_item(input lca_request_t req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req.mode;
		s_axis_tdata  <= {{PAD_W{1'b0}}, req.qy, req.qx, req.leader, req.depth,
			req.parent, req.node};
		do @(posedge clk); while (!s_axis_tready);
		apply_request(req);
	endtask

	// Builds a random tree on distinct node ids. Each node continues its
	// parent's chain only if no sibling has taken that chain yet. The root
	// is its own parent, so a corrupted walk never leaves the written nodes.
	task automatic build_tree(input int n);
		bit    used  [NODES_DEF];
		bit    heavy [NODES_DEF];
		node_t id;
		node_t p;
		node_t ldr;
		tree_ids.delete();
		for (int i = 0; i < n; i++) begin
			do id = node_t'($urandom_range(0, NODES_DEF - 1)); while (used[id]);
			used[id] = 1'b1;
			if (i == 0) begin
				send_item(make_write(id, id, '0, id));
			end else begin
				p = $urandom_range(0, 1) ? tree_ids[i-1] : tree_ids[$urandom_range(0, i - 1)];
				if (!heavy[p] && $urandom_range(0, 2) != 0) begin
					heavy[p] = 1'b1;
					ldr = ldr_tbl[p];
				end else begin
					ldr = id;
				end
				send_item(make_write(id, p, node_t'(dep_tbl[p] + 1'b1), ldr));
			end
			tree_ids.insert(tree_ids.size(), id);
		end
	endtask

	task automatic ask_queries(input int count);
		node_t x;
		repeat (count) begin
			x = tree_ids[$urandom_range(0, tree_ids.size() - 1)];
			if ($urandom_range(0, 7) == 0)
				send_item(make_query(x, x));
			else
				send_item(make_query(x, tree_ids[$urandom_range(0, tree_ids.size() - 1)]));
		end
	endtask

	// A hand-made table: all-ones and all-zeros ids, fields and depths, a tie
	// of leader depths, two nodes at equal depth on one chain, and a pair of
	// self-parented chains that never meet and so run into the hop limit.
	task automatic test_directed_cases();
		send_item(make_write(10'd1023, 10'd0,    10'd0,    10'd1023));
		send_item(make_write(10'd0,    10'd1023, 10'd1,    10'd1023));
		send_item(make_write(10'd512,  10'd1023, 10'd1,    10'd512));
		send_item(make_write(10'd341,  10'd0,    10'd2,    10'd1023));
		send_item(make_write(10'd682,  10'd512,  10'd2,    10'd512));
		send_item(make_write(10'd1,    10'd341,  10'd3,    10'd1));
		send_item(make_write(10'd1022, 10'd682,  10'd1023, 10'd1022));
		send_item(make_write(10'd3,    10'd1023, 10'd1,    10'd3));
		send_item(make_write(10'd4,    10'd1023, 10'd1,    10'd1023));
		send_item(make_write(10'd5,    10'd5,    10'd7,    10'd5));
		send_item(make_write(10'd6,    10'd6,    10'd7,    10'd6));
		send_item(make_query(10'd1022, 10'd1));
		send_item(make_query(10'd682,  10'd3));
		send_item(make_query(10'd3,    10'd682));
		send_item(make_query(10'd0,    10'd4));
		send_item(make_query(10'd4,    10'd0));
		send_item(make_query(10'd1023, 10'd1023));
		send_item(make_query(10'd0,    10'd1022));
		send_item(make_query(10'd1,    10'd0));
		send_item(make_query(10'd5,    10'd6));
		send_item(make_query(10'd1023, 10'd0));
	endtask

	task automatic test_random_trees();
		int n;
		while (writes_sent + queries_sent < 1150) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 24);
			build_tree(n);
			ask_queries($urandom_range(n, 2 * n));
		end
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		build_tree(16);
		ask_queries(40);
		steady = 1'b0;
	endtask

	// Entries of a finished tree are overwritten with parent and leader ids from the
	// same tree and a random depth, which may leave cycles that only the hop limit ends.
	task automatic test_corrupted_tables();
		int victim;
		repeat (12) begin
			build_tree($urandom_range(3, 10));
			ask_queries(3);
			repeat ($urandom_range(1, 3)) begin
				victim = $urandom_range(0, tree_ids.size() - 1);
				send_item(make_write(tree_ids[victim],
					tree_ids[$urandom_range(0, tree_ids.size() - 1)], node_t'($urandom),
					tree_ids[$urandom_range(0, tree_ids.size() - 1)]));
			end
			ask_queries(4);
		end
	endtask

	// Result side: random back-pressure.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			answers_checked++;
			if (m_axis_tuser)
				hop_limit_hits++;
			if (pending_answers.size() == 0) begin
				if (mismatches < 10)
					$display("[%0t] result with no query pending: ancestor %0d walk_failed %0b",
						$realtime, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (m_axis_tdata !== OUT_TDATA_W'(want.ancestor) || m_axis_tuser !== want.failed) begin
					if (mismatches < 10)
						$display("[%0t] wrong result: expected ancestor %0d walk_failed %0b, got ancestor %0d walk_failed %0b",
							$realtime, want.ancestor, want.failed, m_axis_tdata, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		steady        = 1'b0;
		quiet_cycles  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_trees();
		test_back_to_back();
		test_corrupted_tables();

		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d table writes and %0d ancestor queries over random trees and corrupted tables.",
			writes_sent, queries_sent);
		$display("Checked %0d results, %0d of them at the hop limit; %0d mismatches.",
			answers_checked, hop_limit_hits, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/lcaq_pkg.sv
rtl/lca_chain_query_engine.sv
sim/tb_lca_chain_query_engine.sv
